/* hdl/oprd_pkg.sv */
// shared types and constants for the optical pulse rate detector
`timescale 1ns / 1ps
package oprd_pkg;
    localparam int unsigned LP_B = 16072;
    localparam int unsigned LP_A = 33392;
    localparam int unsigned MS_PER_MIN = 60000;

    localparam logic [1:0] CFG_MIN = 2'd0;
    localparam logic [1:0] CFG_MAX = 2'd1;
    localparam logic [1:0] CFG_ALPHA = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_UP   = 2'd1,
        PH_DOWN = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        DIV_NONE = 3'd0,
        DIV_MEAN = 3'd1,
        DIV_BPM  = 3'd2,
        DIV_AVG  = 3'd3
    } t_div_sel;

    typedef struct packed {
        logic dc_step;
        logic mean_step;
        logic lp_mul;
        logic lp_step;
        logic det_step;
        logic div_start;
        t_div_sel div_sel;
        logic rate_push;
        logic avg_take;
        logic out_load;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic beat_end;
        logic span_zero;
    } t_sts;
endpackage

/* hdl/oprd_divider.sv */
// restoring divider, one quotient bit per cycle, unsigned magnitudes
`timescale 1ns / 1ps
module oprd_divider
    import oprd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [39:0] i_den,
    output logic        o_done,
    output logic [39:0] o_quot
);
    logic [39:0] r_rem, n_rem;
    logic [39:0] r_quot, n_quot;
    logic [39:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [40:0] w_trial;

    assign w_trial = {r_rem, r_quot[39]};
    always_comb begin
        if (w_trial >= {1'b0, r_den}) begin
            n_rem  = 40'(w_trial - {1'b0, r_den});
            n_quot = {r_quot[38:0], 1'b1};
        end else begin
            n_rem  = w_trial[39:0];
            n_quot = {r_quot[38:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd40;
                r_rem  <= '0;
                r_quot <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

/* hdl/oprd_datapath.sv */
// filter chain, beat detector registers and rate averaging
`timescale 1ns / 1ps
module oprd_datapath
    import oprd_pkg::*;
#(
    parameter int MEAN_WINDOW = 16,
    parameter int RATE_WINDOW = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic [15:0]        i_ir_sample,
    input  logic [31:0]        i_time_ms,
    output logic               o_beat,
    output logic [15:0]        o_bpm_average,
    output logic signed [31:0] o_filtered_value
);
    localparam int MW = (MEAN_WINDOW > 1) ? $clog2(MEAN_WINDOW) : 1;
    localparam int MF = $clog2(MEAN_WINDOW + 1);
    localparam int RW = (RATE_WINDOW > 1) ? $clog2(RATE_WINDOW) : 1;
    localparam int RF = $clog2(RATE_WINDOW + 1);
    localparam int MT = 32 + MF;
    localparam int RT = 16 + RF;

    logic [15:0] r_min, r_max, r_alpha;
    logic [31:0] r_dc;
    logic [31:0] r_time;
    logic signed [31:0] r_mean_ring [MEAN_WINDOW];
    logic signed [MT-1:0] r_mean_total;
    logic [MW-1:0] r_mean_slot;
    logic [MF-1:0] r_mean_fill;
    logic signed [31:0] r_d;
    logic signed [33:0] r_m;
    logic signed [31:0] r_lp_old, r_lp_new;
    logic signed [63:0] r_pb, r_pa;
    logic signed [31:0] r_fv;
    t_phase r_phase;
    logic signed [31:0] r_prev;
    logic [31:0] r_peak, r_prior;
    logic [15:0] r_rate_ring [RATE_WINDOW];
    logic [RT-1:0] r_rate_total;
    logic [RW-1:0] r_rate_slot;
    logic [RF-1:0] r_rate_fill;
    logic [15:0] r_rate_cur;
    logic r_beat_end;
    logic r_beat;
    logic [15:0] r_bpm_q;
    logic r_mean_neg;
    logic r_o_beat;
    logic [15:0] r_o_bpm;
    logic signed [31:0] r_o_fv;

    logic [47:0] w_prod;
    logic [32:0] w_sum;
    logic [31:0] w_w;
    logic signed [33:0] w_diff;
    logic signed [MT-1:0] w_total;
    logic [39:0] w_num, w_den, w_quot;
    logic w_div_done;
    logic signed [64:0] w_t;
    logic signed [64:0] w_fl;
    logic signed [31:0] w_lpn;
    logic signed [32:0] w_s;
    logic signed [32:0] w_sq;
    logic [31:0] w_span;
    logic signed [33:0] w_mq;
    logic signed [32:0] w_min_s, w_max_s;

    oprd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_prod = 48'(r_alpha) * 48'(r_dc);
    assign w_sum = 33'(i_ir_sample) + 33'(w_prod[47:16]);
    assign w_w = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
    assign w_diff = 34'(w_w) - 34'(r_dc);
    assign w_total = r_mean_total - MT'(r_mean_ring[r_mean_slot]) + MT'(r_d);
    assign w_span = r_peak - r_prior;
    assign w_min_s = $signed({17'd0, r_min});
    assign w_max_s = $signed({17'd0, r_max});

    always_comb begin
        w_num = '0;
        w_den = 40'd1;
        unique case (i_cmd.div_sel)
            DIV_MEAN: begin
                w_num = 40'(r_mean_neg ? -r_mean_total : r_mean_total);
                w_den = 40'(r_mean_fill);
            end
            DIV_BPM: begin
                w_num = 40'(MS_PER_MIN);
                w_den = 40'(w_span);
            end
            DIV_AVG: begin
                w_num = 40'(r_rate_total);
                w_den = 40'(r_rate_fill);
            end
            default: ;
        endcase
    end

    assign w_mq = r_mean_neg ? -34'(w_quot) : 34'(w_quot);
    assign w_t = 65'(r_pb) + 65'(r_pa) + 65'sd32768;
    assign w_fl = w_t >>> 16;
    assign w_lpn = (w_fl > 65'sd2147483647) ? 32'sh7FFF_FFFF :
                   (w_fl < -65'sd2147483648) ? 32'sh8000_0000 : 32'(w_fl);
    assign w_s = 33'(r_lp_old) + 33'(w_lpn);
    assign w_sq = (w_s + ((w_s < 0) ? 33'sd255 : 33'sd0)) >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 16'd100;
            r_max <= 16'd2000;
            r_alpha <= 16'd62259;
            r_dc <= '0;
            for (int i = 0; i < MEAN_WINDOW; i++) r_mean_ring[i] <= '0;
            r_mean_total <= '0;
            r_mean_slot <= '0;
            r_mean_fill <= '0;
            r_lp_old <= '0;
            r_lp_new <= '0;
            r_phase <= PH_IDLE;
            r_prev <= '0;
            r_peak <= '0;
            r_prior <= '0;
            for (int i = 0; i < RATE_WINDOW; i++) r_rate_ring[i] <= '0;
            r_rate_total <= '0;
            r_rate_slot <= '0;
            r_rate_fill <= '0;
            r_rate_cur <= '0;
            r_beat_end <= 1'b0;
            r_beat <= 1'b0;
            r_o_beat <= 1'b0;
            r_o_bpm <= '0;
            r_o_fv <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MIN: r_min <= i_cfg_data;
                    CFG_MAX: r_max <= i_cfg_data;
                    CFG_ALPHA: r_alpha <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.dc_step) begin
                r_dc <= w_w;
                r_time <= i_time_ms;
                r_d <= (w_diff > 34'sd2147483647) ? 32'sh7FFF_FFFF :
                       (w_diff < -34'sd2147483648) ? 32'sh8000_0000 : 32'(w_diff);
            end
            if (i_cmd.mean_step) begin
                r_mean_ring[r_mean_slot] <= r_d;
                r_mean_total <= w_total;
                r_mean_neg <= w_total < 0;
                r_mean_slot <= (r_mean_slot == MW'(MEAN_WINDOW - 1)) ? '0 : r_mean_slot + 1'b1;
                if (r_mean_fill < MF'(MEAN_WINDOW)) r_mean_fill <= r_mean_fill + 1'b1;
            end
            if (i_cmd.lp_mul) begin
                r_m <= w_mq - 34'(r_d);
            end
            if (i_cmd.lp_step) begin
                r_pb <= 64'(r_m) * 64'(LP_B * 256);
                r_pa <= 64'(r_lp_new) * 64'(LP_A);
                r_lp_old <= r_lp_new;
            end
            if (i_cmd.det_step) begin
                r_lp_new <= w_lpn;
                r_fv <= 32'(w_sq);
                r_beat_end <= 1'b0;
                r_beat <= 1'b0;
                if (w_sq > w_max_s) begin
                    r_phase <= PH_IDLE;
                    r_prev <= '0;
                    r_peak <= '0;
                    r_prior <= '0;
                end else begin
                    unique case (r_phase)
                        PH_UP: begin
                            if (w_sq > 33'(r_prev)) begin
                                r_peak <= r_time;
                                r_prev <= 32'(w_sq);
                            end else begin
                                r_beat_end <= 1'b1;
                                r_beat <= 1'b1;
                                r_phase <= PH_DOWN;
                            end
                        end
                        PH_DOWN: begin
                            if (w_sq < w_min_s) r_phase <= PH_IDLE;
                            r_prev <= 32'(w_sq);
                        end
                        default: begin
                            r_phase <= (w_sq >= w_min_s) ? PH_UP : PH_IDLE;
                            r_prev <= 32'(w_sq);
                        end
                    endcase
                end
            end
            if (i_cmd.rate_push) begin
                r_bpm_q <= (w_span == '0) ? 16'd0 : w_quot[15:0];
                r_prior <= r_peak;
            end
            if (i_cmd.avg_take) begin
                r_rate_cur <= w_quot[15:0];
            end
            if (i_cmd.out_load && r_beat_end) begin
                r_rate_ring[r_rate_slot] <= r_bpm_q;
                r_rate_total <= r_rate_total - RT'(r_rate_ring[r_rate_slot]) + RT'(r_bpm_q);
                r_rate_slot <= (r_rate_slot == RW'(RATE_WINDOW - 1)) ? '0 : r_rate_slot + 1'b1;
                if (r_rate_fill < RF'(RATE_WINDOW)) r_rate_fill <= r_rate_fill + 1'b1;
                r_beat_end <= 1'b0;
            end
            if (i_cmd.res_load) begin
                r_o_beat <= r_beat;
                r_o_bpm <= r_rate_cur;
                r_o_fv <= r_fv;
            end
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.beat_end = r_beat_end;
    assign o_sts.span_zero = (w_span == '0);
    assign o_beat = r_o_beat;
    assign o_bpm_average = r_o_bpm;
    assign o_filtered_value = r_o_fv;
endmodule

/* hdl/oprd_ctrl.sv */
// sequencing state machine for one sample
`timescale 1ns / 1ps
module oprd_ctrl
    import oprd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MEAN  = 13'b0000000000010,
        S_MDIV  = 13'b0000000000100,
        S_MWAIT = 13'b0000000001000,
        S_LPM   = 13'b0000000010000,
        S_DET   = 13'b0000000100000,
        S_BDIV  = 13'b0000001000000,
        S_BWAIT = 13'b0000010000000,
        S_PUSH  = 13'b0000100000000,
        S_AWAIT = 13'b0001000000000,
        S_OUT   = 13'b0010000000000,
        S_LPS   = 13'b0100000000000,
        S_LOAD  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd.dc_step = 1'b1;
                n_state = S_MEAN;
            end
            S_MEAN: begin o_cmd.mean_step = 1'b1; n_state = S_MDIV; end
            S_MDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel = DIV_MEAN;
                n_state = S_MWAIT;
            end
            S_MWAIT: if (i_sts.div_done) begin
                o_cmd.lp_mul = 1'b1;
                n_state = S_LPM;
            end
            S_LPM: begin o_cmd.lp_step = 1'b1; n_state = S_LPS; end
            S_LPS: begin o_cmd.det_step = 1'b1; n_state = S_DET; end
            S_DET: n_state = i_sts.beat_end ? S_BDIV : S_LOAD;
            S_BDIV: begin
                o_cmd.div_start = !i_sts.span_zero;
                o_cmd.div_sel = DIV_BPM;
                n_state = S_BWAIT;
            end
            S_BWAIT: if (i_sts.span_zero || i_sts.div_done) begin
                o_cmd.div_sel = DIV_BPM;
                o_cmd.rate_push = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.out_load = 1'b1;
                n_state = S_AWAIT;
            end
            S_AWAIT: begin
                o_cmd.div_sel = DIV_AVG;
                o_cmd.div_start = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (i_sts.div_done) begin
                o_cmd.avg_take = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: if (!r_out_valid || i_ready) begin
                o_cmd.res_load = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
endmodule

/* hdl/optical_pulse_rate_detector_core.sv */
// top level of the optical pulse rate detector
`timescale 1ns / 1ps
// Each accepted sample gives one result. A sample that ends no pulse runs
// only the running-mean division; one that ends a pulse also runs the
// 60000/interval rate division, skipped when that pulse has a zero
// interval, and then the rate-average division. All three use the shared
// 40-step restoring divider. The result sits in an output register until
// taken, so the next sample is accepted and processed meanwhile; its own
// result waits until that register is free.
module optical_pulse_rate_detector_core
    import oprd_pkg::*;
#(
    parameter int MEAN_WINDOW = 16,
    parameter int RATE_WINDOW = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_ir_sample,
    input  logic [31:0]        i_time_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_beat,
    output logic [15:0]        o_bpm_average,
    output logic signed [31:0] o_filtered_value
);
    t_cmd w_cmd;
    t_sts w_sts;

    oprd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    oprd_datapath #(
        .MEAN_WINDOW (MEAN_WINDOW),
        .RATE_WINDOW (RATE_WINDOW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_ir_sample      (i_ir_sample),
        .i_time_ms        (i_time_ms),
        .o_beat           (o_beat),
        .o_bpm_average    (o_bpm_average),
        .o_filtered_value (o_filtered_value)
    );
endmodule

/* tb/optical_pulse_rate_detector_core_tb.sv */
// testbench for the optical pulse rate detector core: table-driven and random samples
`timescale 1ns / 1ps
module optical_pulse_rate_detector_core_tb
    import oprd_pkg::*;
();

    localparam int MEAN_N = 16;
    localparam int RATE_N = 8;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [15:0] ir;
        logic [31:0] ms;
        bit          known;
        logic        beat;
        logic [15:0] bpm;
        logic [31:0] fv;
    } t_row;

    typedef struct {
        logic        beat;
        logic [15:0] bpm;
        logic [31:0] fv;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_ir_sample;
    logic [31:0] i_time_ms;
    logic        o_valid;
    logic        i_ready;
    logic        o_beat;
    logic [15:0] o_bpm_average;
    logic signed [31:0] o_filtered_value;

    optical_pulse_rate_detector_core DUT (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // predictor state
    logic [15:0] thr_min, thr_max, alpha;
    logic [31:0] dc_lvl;
    longint      mring [MEAN_N];
    longint      msum;
    int          mslot, mfill;
    longint      lp_old, lp_new;
    t_phase      phase;
    longint      prev_fv;
    logic [31:0] t_peak, t_prior;
    int unsigned rring [RATE_N];
    int unsigned rsum;
    int          rslot, rfill;
    logic [15:0] bpm_now;

    t_res        pending [$];
    int          errors;
    int          idle_cycles;
    int          send_idle, recv_stall;
    logic [31:0] clock_ms;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor16(longint t);
        if (t >= 0) return t >>> 16;
        return -((-t + 65535) >>> 16);
    endfunction

    task automatic predictor_clear();
        thr_min = 16'd100; thr_max = 16'd2000; alpha = 16'd62259;
        dc_lvl = '0; msum = 0; mslot = 0; mfill = 0;
        foreach (mring[i]) mring[i] = 0;
        lp_old = 0; lp_new = 0; phase = PH_IDLE; prev_fv = 0;
        t_peak = '0; t_prior = '0;
        foreach (rring[i]) rring[i] = 0;
        rsum = 0; rslot = 0; rfill = 0; bpm_now = '0;
    endtask

    function automatic t_res pulse_predict(logic [15:0] x, logic [31:0] now);
        longint unsigned w;
        longint d, m, t, fv;
        int unsigned span, rate;
        t_res r;
        r.beat = 0;
        w = longint'(x) + ((longint'(alpha) * longint'(dc_lvl)) >> 16);
        if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
        d = clamp32(longint'(w) - longint'(dc_lvl));
        dc_lvl = w[31:0];
        msum = msum - mring[mslot] + d;
        mring[mslot] = d;
        mslot = (mslot + 1) % MEAN_N;
        if (mfill < MEAN_N) mfill++;
        m = msum / mfill - d;
        lp_old = lp_new;
        t = longint'(LP_B) * m * 256 + longint'(LP_A) * lp_old + 32768;
        lp_new = clamp32(floor16(t));
        fv = clamp32((lp_old + lp_new) / 256);
        if (fv > longint'(thr_max)) begin
            phase = PH_IDLE; prev_fv = 0; t_peak = '0; t_prior = '0;
        end else begin
            if (phase == PH_UP) begin
                if (fv > prev_fv) begin
                    t_peak = now;
                    prev_fv = fv;
                end else begin
                    span = t_peak - t_prior;
                    rate = (span > 0) ? MS_PER_MIN / span : 0;
                    t_prior = t_peak;
                    rsum = rsum - rring[rslot] + rate;
                    rring[rslot] = rate;
                    rslot = (rslot + 1) % RATE_N;
                    if (rfill < RATE_N) rfill++;
                    bpm_now = 16'(rsum / rfill);
                    phase = PH_DOWN;
                    r.beat = 1;
                end
            end else begin
                if (phase == PH_DOWN) begin
                    if (fv < longint'(thr_min)) phase = PH_IDLE;
                end else begin
                    phase = (fv >= longint'(thr_min)) ? PH_UP : PH_IDLE;
                end
                prev_fv = fv;
            end
        end
        r.bpm = bpm_now;
        r.fv = fv[31:0];
        return r;
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MIN) thr_min = val;
        else if (idx == CFG_MAX) thr_max = val;
        else if (idx == CFG_ALPHA) alpha = val;
    endtask

    task automatic push_sample(logic [15:0] x, logic [31:0] now);
        if (send_idle > 0) begin
            while ($urandom_range(99) < send_idle) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_ir_sample <= x;
        i_time_ms <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending.push_back(pulse_predict(x, now));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic run_random(int n, int mode);
        logic [15:0] x;
        for (int k = 0; k < n; k++) begin
            clock_ms += $urandom_range(20, 1);
            case (mode)
                0: x = 16'($urandom);
                1: x = ($urandom_range(9) < 5) ? 16'hFFFF : 16'h0000;
                default: x = 16'(16'd30000 + (((clock_ms / 400) % 2) ? 16'd3000 : 16'd0)
                             + $urandom_range(60));
            endcase
            if ($urandom_range(99) < 3) push_sample(x, $urandom);
            else push_sample(x, clock_ms);
        end
    endtask

    // receiver side and checking
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat=%0d", o_beat);
                end else begin
                    e = pending.pop_front();
                    if (o_beat !== e.beat || o_bpm_average !== e.bpm
                            || o_filtered_value !== e.fv) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     e.beat, e.bpm, $signed(e.fv),
                                     o_beat, o_bpm_average, o_filtered_value);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("optical_pulse_rate_detector_core_tb NOT OK");
            $finish;
        end
    end

    t_row rows [$];

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ir_sample = '0;
        i_time_ms = '0;
        send_idle = 0;
        recv_stall = 0;
        clock_ms = 0;
        predictor_clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zeros at reset are known, then extremes
        rows.push_back('{16'h0000, 32'd0, 1, 1'b0, 16'd0, 32'd0});
        rows.push_back('{16'h0000, 32'd10, 1, 1'b0, 16'd0, 32'd0});
        rows.push_back('{16'hFFFF, 32'd20, 0, 0, 0, 0});
        rows.push_back('{16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0, 0});
        rows.push_back('{16'h0000, 32'd40, 0, 0, 0, 0});
        for (int k = 0; k < 10; k++)
            rows.push_back('{16'h0000, 32'd100 + k * 30, 0, 0, 0, 0});
        for (int k = 0; k < 8; k++)
            rows.push_back('{(k < 3) ? 16'd800 : 16'd0, 32'd500 + k * 25, 0, 0, 0, 0});
        foreach (rows[i]) begin
            if (rows[i].known) begin
                void'(pulse_predict(rows[i].ir, rows[i].ms));
                pending.push_back('{rows[i].beat, rows[i].bpm, rows[i].fv});
                i_valid <= 1'b1;
                i_ir_sample <= rows[i].ir;
                i_time_ms <= rows[i].ms;
                @(posedge i_clk);
                while (!o_ready) @(posedge i_clk);
            end else begin
                push_sample(rows[i].ir, rows[i].ms);
            end
        end
        drain_results();

        // default config, no idling
        run_random(200, 2);
        drain_results();
        cfg_write(CFG_MIN, 16'd0);
        cfg_write(CFG_MAX, 16'hFFFF);
        cfg_write(CFG_ALPHA, 16'hFFFF);
        cfg_write(2'd3, 16'h1234);
        send_idle = 88;
        run_random(150, 1);
        run_random(100, 0);
        drain_results();
        cfg_write(CFG_MIN, 16'd50);
        cfg_write(CFG_MAX, 16'd400);
        cfg_write(CFG_ALPHA, 16'd0);
        send_idle = 0;
        recv_stall = 88;
        run_random(200, 2);
        drain_results();
        cfg_write(CFG_MIN, 16'hFFFF);
        cfg_write(CFG_MAX, 16'd0);
        cfg_write(CFG_ALPHA, 16'd32768);
        send_idle = 6;
        recv_stall = 6;
        run_random(100, 0);
        drain_results();
        cfg_write(CFG_MIN, 16'd100);
        cfg_write(CFG_MAX, 16'd2000);
        cfg_write(CFG_ALPHA, 16'd62259);
        run_random(280, 2);
        drain_results();

        if (errors == 0 && pending.size() == 0) begin
            $display("optical_pulse_rate_detector_core_tb OK");
        end else begin
            $display("optical_pulse_rate_detector_core_tb NOT OK");
        end
        $finish;
    end
endmodule
